// File: hdl/satd8t_pkg.sv
// shared types, widths and the 8-point hadamard butterfly for the tiled satd core
package satd8t_pkg;

    // geometry and field widths
    localparam int ROWS    = 8;
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int COEF_W  = 15;
    localparam int ABS_W   = 14;
    localparam int LSUM_W  = 17;
    localparam int TSUM_W  = 20;
    localparam int TOTAL_W = 24;
    localparam int CODE_W  = 2;
    localparam int RIDX_W  = 3;
    localparam int LINE_W  = ROWS * PIX_W;

    localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(ROWS - 1);

    // coefficient and row types
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_vec_t [ROWS];
    typedef logic signed [ROW_W-1:0] hrow_t;
    typedef hrow_t hrow_vec_t [ROWS];
    typedef logic [ABS_W-1:0] mag_t;
    typedef mag_t mag_vec_t [ROWS];
    typedef logic [LSUM_W-1:0] lsum_t;
    typedef lsum_t lsum_vec_t [ROWS];

    // three butterfly levels, output order matches the row store layout
    function automatic coef_vec_t hadamard8(input coef_vec_t v);
        coef_vec_t t;
        coef_vec_t u;
        coef_vec_t w;
        for (int i = 0; i < 4; i++)
        begin
            t[i]     = v[2*i] + v[2*i+1];
            t[i + 4] = v[2*i] - v[2*i+1];
        end
        for (int i = 0; i < 2; i++)
        begin
            u[i]     = t[2*i] + t[2*i+1];
            u[i + 2] = t[2*i] - t[2*i+1];
            u[i + 4] = t[4+2*i] + t[5+2*i];
            u[i + 6] = t[4+2*i] - t[5+2*i];
        end
        for (int i = 0; i < 4; i++)
        begin
            w[2*i]   = u[2*i] + u[2*i+1];
            w[2*i+1] = u[2*i] - u[2*i+1];
        end
        return w;
    endfunction

endpackage

// File: hdl/satd8t_row_xform.sv
// pixel differences and horizontal 8-point hadamard of one row pair
module satd8t_row_xform
(
    input  logic [satd8t_pkg::LINE_W-1:0] a_row,
    input  logic [satd8t_pkg::LINE_W-1:0] b_row,
    output satd8t_pkg::hrow_vec_t         row
);

    satd8t_pkg::coef_vec_t diff;
    satd8t_pkg::coef_vec_t xf;

    // signed differences, widened to coefficient width
    always_comb
    begin
        for (int i = 0; i < satd8t_pkg::ROWS; i++)
        begin
            diff[i] = satd8t_pkg::COEF_W'(
                $signed({1'b0, a_row[i*satd8t_pkg::PIX_W +: satd8t_pkg::PIX_W]}) -
                $signed({1'b0, b_row[i*satd8t_pkg::PIX_W +: satd8t_pkg::PIX_W]}));
        end
    end

    // transform and trim to stored row width
    always_comb
    begin
        xf = satd8t_pkg::hadamard8(diff);
        for (int i = 0; i < satd8t_pkg::ROWS; i++)
        begin
            row[i] = xf[i][satd8t_pkg::ROW_W-1:0];
        end
    end

endmodule

// File: hdl/satd8t_col_lane.sv
// one column lane: vertical hadamard, magnitudes, then column sum
module satd8t_col_lane
(
    input  logic                  clk,
    input  logic                  load_en,
    input  logic                  sum_en,
    input  satd8t_pkg::hrow_vec_t col,
    output satd8t_pkg::lsum_t     lane_sum
);

    satd8t_pkg::coef_vec_t col_ext;
    satd8t_pkg::coef_vec_t vt;
    satd8t_pkg::mag_vec_t  mag_next;
    satd8t_pkg::mag_vec_t  mag_reg;
    satd8t_pkg::lsum_t     sum_next;
    satd8t_pkg::lsum_t     sum_reg;

    // vertical transform and absolute values
    always_comb
    begin
        for (int i = 0; i < satd8t_pkg::ROWS; i++)
        begin
            col_ext[i] = satd8t_pkg::COEF_W'(col[i]);
        end
        vt = satd8t_pkg::hadamard8(col_ext);
        for (int i = 0; i < satd8t_pkg::ROWS; i++)
        begin
            mag_next[i] = vt[i][satd8t_pkg::COEF_W-1] ? satd8t_pkg::ABS_W'(-vt[i])
                                                      : satd8t_pkg::ABS_W'(vt[i]);
        end
    end

    // sum of the eight magnitudes
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < satd8t_pkg::ROWS; i++)
        begin
            sum_next = sum_next + satd8t_pkg::LSUM_W'(mag_reg[i]);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            mag_reg <= mag_next;
        end
        if (sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign lane_sum = sum_reg;

endmodule

// File: hdl/satd8t_merge.sv
// merges lane sums into a tile value, accumulates tiles and holds the result item
module satd8t_merge
#(
    parameter int MAX_BLOCK_SIZE = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [satd8t_pkg::CODE_W-1:0]        block_size_code,
    input  logic                                 tile_vld,
    input  satd8t_pkg::lsum_vec_t                lane_sums,
    output logic                                 hold,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [satd8t_pkg::TOTAL_W-1:0]       satd_total
);

    localparam int MAX_SIDE  = MAX_BLOCK_SIZE / 8;
    localparam int MAX_TILES = MAX_SIDE * MAX_SIDE;
    localparam int TILE_W    = $clog2(MAX_TILES + 1);

    logic [satd8t_pkg::CODE_W-1:0]  code_reg;
    logic                           tsum_vld_reg;
    logic                           tsum_vld_next;
    logic [satd8t_pkg::TSUM_W-1:0]  tsum_reg;
    logic [satd8t_pkg::TSUM_W-1:0]  tsum_next;
    logic [TILE_W-1:0]              tile_idx_reg;
    logic [TILE_W-1:0]              tile_idx_next;
    logic [TILE_W-1:0]              tile_inc;
    logic [satd8t_pkg::TOTAL_W-1:0] run_reg;
    logic [satd8t_pkg::TOTAL_W-1:0] run_next;
    logic [satd8t_pkg::TOTAL_W-1:0] total_sum;
    logic [satd8t_pkg::TSUM_W:0]    rounded;
    logic                           last_tile;
    logic                           adv;
    logic                           emit;
    logic                           out_vld_reg;
    logic                           out_vld_next;
    logic [satd8t_pkg::TOTAL_W-1:0] out_data_reg;

    // tiles per block for a size code, clamped to the largest block
    function automatic logic [TILE_W-1:0] tile_count(input logic [satd8t_pkg::CODE_W-1:0] code);
        int size;
        int side;
        size = 8 << code;
        if (size > MAX_BLOCK_SIZE)
        begin
            size = MAX_BLOCK_SIZE;
        end
        side = size >> 3;
        if (side == 0)
        begin
            side = 1;
        end
        return TILE_W'(side * side);
    endfunction

    // adder tree over the lane sums
    always_comb
    begin
        tsum_next = '0;
        for (int i = 0; i < satd8t_pkg::ROWS; i++)
        begin
            tsum_next = tsum_next + satd8t_pkg::TSUM_W'(lane_sums[i]);
        end
    end

    // rounding, accumulation and end-of-block decision
    always_comb
    begin
        rounded   = (satd8t_pkg::TSUM_W+1)'(tsum_reg) + (satd8t_pkg::TSUM_W+1)'(2);
        total_sum = run_reg + satd8t_pkg::TOTAL_W'(rounded >> 2);
        tile_inc  = tile_idx_reg + TILE_W'(1);
        last_tile = tile_inc >= tile_count(code_reg);
        emit      = tsum_vld_reg && last_tile;
        hold      = emit && out_vld_reg && out_stall;
        adv       = !hold;
    end

    // next state of the control registers
    always_comb
    begin
        tsum_vld_next = adv ? tile_vld : tsum_vld_reg;
        tile_idx_next = tile_idx_reg;
        run_next      = run_reg;
        if (adv && tsum_vld_reg)
        begin
            if (last_tile)
            begin
                tile_idx_next = '0;
                run_next      = '0;
            end
            else
            begin
                tile_idx_next = tile_inc;
                run_next      = total_sum;
            end
        end
        if (adv && emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg     <= '0;
            tsum_vld_reg <= 1'b0;
            tile_idx_reg <= '0;
            run_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                code_reg <= block_size_code;
            end
            tsum_vld_reg <= tsum_vld_next;
            tile_idx_reg <= tile_idx_next;
            run_reg      <= run_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv && tile_vld)
        begin
            tsum_reg <= tsum_next;
        end
        if (adv && emit)
        begin
            out_data_reg <= total_sum;
        end
    end

    assign out_valid  = out_vld_reg;
    assign satd_total = out_data_reg;

    // a new result item always comes from a finished tile
    a_emit_from_tile: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(tsum_vld_reg))
        else $error("result item without a finished tile");

    // a delivered block leaves the accumulator cleared
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> (tile_idx_reg == '0) && (run_reg == '0))
        else $error("accumulator not cleared after result item");

endmodule

// File: hdl/satd_hadamard_8x8_tiled_core.sv
// top level of the tiled 8x8 hadamard satd core
//
// usage:
//   input channel: in_valid / in_stall with a_row and b_row, one row pair of
//   the two 8x8 tiles per item, rows 0..7 of each tile in order, tiles in
//   raster order of the block. output channel: out_valid / out_stall with
//   satd_total, one item after the last row of the last tile of a block.
//   block_size_code is written with cfg_we while the core is idle; it sets
//   1, 4, 16 or 64 tiles per block.
// throughput: one item per clock while in_stall is low; eight parallel column
//   lanes take a whole tile at once, and a tile ends at most every eighth item.
// pipeline: out_valid rises once the last row of a block has passed the row
//   stage, lane transform, lane sum, tile sum and total registers.
// reset: clears row and tile position, the running total, the size code and
//   all valid bits; the row store holds no data until written.
// stall: a waiting result sits in the output register while items keep
//   flowing; only when a second block total is ready and the first is still
//   stalled does in_stall rise, freezing the pipeline until it is taken.
module satd_hadamard_8x8_tiled_core
#(
    parameter int MAX_BLOCK_SIZE = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [satd8t_pkg::CODE_W-1:0]        block_size_code,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [satd8t_pkg::LINE_W-1:0]        a_row,
    input  logic [satd8t_pkg::LINE_W-1:0]        b_row,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [satd8t_pkg::TOTAL_W-1:0]       satd_total
);

    satd8t_pkg::hrow_vec_t          row_xf;
    satd8t_pkg::hrow_vec_t          rowa_reg;
    logic [satd8t_pkg::RIDX_W-1:0]  rowa_idx_reg;
    logic                           rowa_vld_reg;
    logic                           rowa_vld_next;
    logic [satd8t_pkg::RIDX_W-1:0]  row_idx_reg;
    logic [satd8t_pkg::RIDX_W-1:0]  row_idx_next;
    satd8t_pkg::hrow_vec_t          bank_reg [satd8t_pkg::ROWS-1];
    satd8t_pkg::hrow_vec_t          col_arr [satd8t_pkg::ROWS];
    satd8t_pkg::lsum_vec_t          lane_sums;
    logic                           b_vld_reg;
    logic                           b_vld_next;
    logic                           c_vld_reg;
    logic                           c_vld_next;
    logic                           tile_go;
    logic                           hold;
    logic                           adv;
    logic                           in_acc;

    // handshake and pipeline advance
    assign in_stall = hold;
    assign adv      = !hold;
    assign in_acc   = in_valid && !in_stall;
    assign tile_go  = rowa_vld_reg && (rowa_idx_reg == satd8t_pkg::LAST_ROW);

    // horizontal transform of the incoming row pair
    satd8t_row_xform u_row_xform
    (
        .a_row (a_row),
        .b_row (b_row),
        .row   (row_xf)
    );

    // next state of the row stage and valid chain
    always_comb
    begin
        row_idx_next  = in_acc ? row_idx_reg + satd8t_pkg::RIDX_W'(1) : row_idx_reg;
        rowa_vld_next = adv ? in_acc : rowa_vld_reg;
        b_vld_next    = adv ? tile_go : b_vld_reg;
        c_vld_next    = adv ? b_vld_reg : c_vld_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_idx_reg  <= '0;
            rowa_vld_reg <= 1'b0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
        end
        else
        begin
            row_idx_reg  <= row_idx_next;
            rowa_vld_reg <= rowa_vld_next;
            b_vld_reg    <= b_vld_next;
            c_vld_reg    <= c_vld_next;
        end
    end

    // row stage and store of rows 0..6 of the current tile
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rowa_reg     <= row_xf;
            rowa_idx_reg <= row_idx_reg;
        end
        if (adv && rowa_vld_reg && (rowa_idx_reg != satd8t_pkg::LAST_ROW))
        begin
            bank_reg[rowa_idx_reg] <= rowa_reg;
        end
    end

    // column lanes: stored rows plus the last row straight from the row stage
    always_comb
    begin
        for (int x = 0; x < satd8t_pkg::ROWS; x++)
        begin
            for (int y = 0; y < satd8t_pkg::ROWS - 1; y++)
            begin
                col_arr[x][y] = bank_reg[y][x];
            end
            col_arr[x][satd8t_pkg::ROWS-1] = rowa_reg[x];
        end
    end

    for (genvar x = 0; x < satd8t_pkg::ROWS; x++)
    begin : g_lane
        satd8t_col_lane u_lane
        (
            .clk      (clk),
            .load_en  (adv && tile_go),
            .sum_en   (adv && b_vld_reg),
            .col      (col_arr[x]),
            .lane_sum (lane_sums[x])
        );
    end

    // tile merge, accumulation and output register
    satd8t_merge
    #(
        .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
    )
    u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .block_size_code (block_size_code),
        .tile_vld        (c_vld_reg),
        .lane_sums       (lane_sums),
        .hold            (hold),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .satd_total      (satd_total)
    );

    // tiles are at least eight items apart, so one tile is in flight at most
    a_one_tile_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tile_go, b_vld_reg, c_vld_reg}))
        else $error("two tiles overlap in the lane pipeline");

    // input is held back only behind a stalled result item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result item");

    // a frozen pipeline keeps the row stage in place
    a_freeze_row: assert property (@(posedge clk) disable iff (!rst_n)
        hold && rowa_vld_reg |=> rowa_vld_reg && $stable(rowa_idx_reg))
        else $error("row stage moved while the pipeline was frozen");

endmodule

// File: tb/sv/satd_hadamard_8x8_tiled_core_tb.sv
// testbench for the tiled 8x8 hadamard satd core: predicted block totals checked against the core
`timescale 1ns / 100ps

// tracks the core state from accepted row pairs and holds the block totals still due
class satd_tally;
    logic [1:0]  size_code;
    int          hor[8][8];
    int          row_pos;
    int          tile_pos;
    logic [23:0] block_sum;
    logic [23:0] totals_due[$];
    int          errors;
    int          rows_seen;
    int          totals_seen;

    function new();
        size_code   = 2'd0;
        row_pos     = 0;
        tile_pos    = 0;
        block_sum   = '0;
        errors      = 0;
        rows_seen   = 0;
        totals_seen = 0;
    endfunction

    function void set_code(logic [1:0] code);
        size_code = code;
    endfunction

    // natural-order fast walsh transform, the abs sum is the same for any row order
    function void walsh8(inout int v[8]);
        int p;
        int q;
        for (int span = 1; span < 8; span = span * 2)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if ((i & span) == 0)
                begin
                    p           = v[i];
                    q           = v[i + span];
                    v[i]        = p + q;
                    v[i + span] = p - q;
                end
            end
        end
    endfunction

    // one accepted row pair: horizontal pass, and at tile end the vertical pass and sum
    function void take_rows(logic [63:0] a, logic [63:0] b);
        int lane[8];
        int col[8];
        int sum;
        int tile_val;
        rows_seen++;
        for (int i = 0; i < 8; i++)
            lane[i] = int'(a[8*i +: 8]) - int'(b[8*i +: 8]);
        walsh8(lane);
        hor[row_pos] = lane;
        if (row_pos != 7)
        begin
            row_pos++;
            return;
        end
        row_pos = 0;
        sum     = 0;
        for (int x = 0; x < 8; x++)
        begin
            for (int y = 0; y < 8; y++)
                col[y] = hor[y][x];
            walsh8(col);
            for (int y = 0; y < 8; y++)
                sum += (col[y] < 0) ? -col[y] : col[y];
        end
        tile_val  = (sum + 2) >> 2;
        block_sum = 24'(block_sum + tile_val);
        tile_pos++;
        if (tile_pos >= (1 << (2 * int'(size_code))))
        begin
            totals_due.push_back(block_sum);
            block_sum = '0;
            tile_pos  = 0;
        end
    endfunction

    // one accepted result against the oldest total due
    function void match_total(logic [23:0] got);
        logic [23:0] want;
        totals_seen++;
        if (totals_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected satd_total, expected none, actual %0d", $time, got);
            return;
        end
        want = totals_due.pop_front();
        if (got !== want)
        begin
            errors++;
            $display("%0t: satd_total mismatch, expected %0d, actual %0d", $time, want, got);
        end
    endfunction

    function int pending();
        return totals_due.size();
    endfunction
endclass

module satd_hadamard_8x8_tiled_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic                                clk             = 1'b0;
    logic                                rst_n           = 1'b0;
    logic                                cfg_we          = 1'b0;
    logic [satd8t_pkg::CODE_W-1:0]       block_size_code = '0;
    logic                                in_valid        = 1'b0;
    logic                                in_stall;
    logic [satd8t_pkg::LINE_W-1:0]       a_row           = '0;
    logic [satd8t_pkg::LINE_W-1:0]       b_row           = '0;
    logic                                out_valid;
    logic                                out_stall       = 1'b0;
    logic [satd8t_pkg::TOTAL_W-1:0]      satd_total;

    satd_tally sb = new();

    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    int cycle_count = 0;

    satd_hadamard_8x8_tiled_core #(.MAX_BLOCK_SIZE(64)) DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .block_size_code (block_size_code),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .a_row           (a_row),
        .b_row           (b_row),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .satd_total      (satd_total)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("satd_hadamard_8x8_tiled_core_tb: done, errors");
            $finish;
        end
    end

    // result side: check accepted totals, random stalls and one long hold
    always @(posedge clk)
    begin
        int  hold_left;
        bit  hold_started;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.match_total(satd_total);
            if (hold_req && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 18);
        end
    end

    // offer one row pair, with random idle cycles ahead of it
    task automatic send_row(input logic [63:0] a, input logic [63:0] b);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        a_row    <= a;
        b_row    <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_rows(a, b);
    endtask

    // one tile of eight row pairs in the given content style
    task automatic send_tile(input int style);
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  ma;
        logic [7:0]  mb;
        for (int r = 0; r < 8; r++)
        begin
            a  = {$urandom, $urandom};
            b  = {$urandom, $urandom};
            ma = 8'($urandom);
            mb = 8'($urandom);
            case (style)
                5, 6:
                begin
                    // full-scale bytes only
                    for (int i = 0; i < 8; i++)
                    begin
                        a[8*i +: 8] = ma[i] ? 8'hFF : 8'h00;
                        b[8*i +: 8] = mb[i] ? 8'hFF : 8'h00;
                    end
                end
                7:
                begin
                    // small differences
                    for (int i = 0; i < 8; i++)
                        b[8*i +: 8] = a[8*i +: 8] ^ 8'($urandom_range(3));
                end
                8:
                    b = a;
                9:
                begin
                    a = {64{1'b1}};
                    b = '0;
                end
                10:
                begin
                    a = '0;
                    b = {64{1'b1}};
                end
                11:
                begin
                    // sign alternates along the row and between rows
                    a = r[0] ? 64'hFF00FF00FF00FF00 : 64'h00FF00FF00FF00FF;
                    b = ~a;
                end
                default:
                    ;
            endcase
            send_row(a, b);
        end
    endtask

    // whole blocks of random tiles at the current size
    task automatic send_blocks(input int blocks, input int tiles);
        for (int k = 0; k < blocks * tiles; k++)
            send_tile($urandom_range(9));
        in_valid <= 1'b0;
    endtask

    // wait for the core to drain, then write the size code
    task automatic write_size(input logic [satd8t_pkg::CODE_W-1:0] code);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we          <= 1'b1;
        block_size_code <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_code(code);
    endtask

    // stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tiles at the reset size: max positive, max negative, alternating, equal
        send_tile(9);
        send_tile(10);
        send_tile(11);
        send_tile(8);

        // largest block, then mixed sizes
        write_size(2'd3);
        send_blocks(1, 64);

        write_size(2'd1);
        send_blocks(6, 4);

        // no idling on either side through this phase
        write_size(2'd2);
        calm = 1'b1;
        send_blocks(2, 16);
        calm = 1'b0;

        // smallest block with a long output hold so the core backs up
        write_size(2'd0);
        hold_req = 1'b1;
        send_blocks(60, 1);

        write_size(2'd1);
        send_blocks(2, 4);

        // drain and settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d row pairs and %0d block totals over block sizes 8x8 to 64x64,",
                 sb.rows_seen, sb.totals_seen);
        $display("with random idling, a stall-free phase and a long output hold");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("satd_hadamard_8x8_tiled_core_tb: done, clean");
        else
            $display("satd_hadamard_8x8_tiled_core_tb: done, errors");
        $finish;
    end
endmodule
